/* rtl/rau_pkg.sv */
// Package for the rational arithmetic unit: payload structs, operation codes
// and the operand width. No dependencies.
package rau_pkg;
  localparam int OperandWidth = 32;
  localparam int WideWidth = 64;

  localparam logic [2:0] OP_NORM = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic signed [63:0] res_den;
    logic den_zero;
  } res_t;

  // raw fraction handed from front to back
  typedef struct packed {
    logic [WideWidth-1:0] num;
    logic [WideWidth-1:0] den;
  } raw_t;

  function automatic logic signed [WideWidth-1:0] sext_op(input logic [31:0] v);
    logic signed [OperandWidth-1:0] t;
    t = v[OperandWidth-1:0];
    return WideWidth'(t);
  endfunction
endpackage

/* rtl/rau_front.sv */
// Front end: accepts requests and forms raw numerator and denominator with
// registered cross products. Depends on rau_pkg.
module rau_front (
  input  logic clk,
  input  logic rst,
  input  rau_pkg::req_t req,
  input  logic req_valid,
  output logic req_ready,
  output rau_pkg::raw_t raw,
  output logic raw_valid,
  input  logic raw_ready
);
  import rau_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [2:0] op;
  logic signed [OperandWidth-1:0] an, ad, bn, bd;
  logic [WideWidth-1:0] p0, p1, p2, p3;

  assign req_ready = (state == S_IDLE);
  assign raw_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (req_valid) state <= S_MUL;
        S_MUL: state <= S_SUM;
        S_SUM: state <= S_OUT;
        S_OUT: if (raw_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op <= req.req_type;
      an <= req.a_num[OperandWidth-1:0];
      ad <= req.a_den[OperandWidth-1:0];
      bn <= req.b_num[OperandWidth-1:0];
      bd <= req.b_den[OperandWidth-1:0];
    end
    if (state == S_MUL) begin
      p0 <= WideWidth'(an) * WideWidth'(bd);
      p1 <= WideWidth'(ad) * WideWidth'(bn);
      p2 <= WideWidth'(an) * WideWidth'(bn);
      p3 <= WideWidth'(ad) * WideWidth'(bd);
    end
    if (state == S_SUM) begin
      unique case (op)
        OP_ADD: begin raw.num <= p0 + p1; raw.den <= p3; end
        OP_SUB: begin raw.num <= p0 - p1; raw.den <= p3; end
        OP_MUL: begin raw.num <= p2; raw.den <= p3; end
        OP_DIV: begin raw.num <= p0; raw.den <= p1; end
        default: begin raw.num <= sext_op(an); raw.den <= sext_op(ad); end
      endcase
    end
  end
endmodule

/* rtl/rau_queue.sv */
// Two-entry queue between front and back ends. Depends on rau_pkg.
module rau_queue (
  input  logic clk,
  input  logic rst,
  input  rau_pkg::raw_t in_data,
  input  logic in_valid,
  output logic in_ready,
  output rau_pkg::raw_t out_data,
  output logic out_valid,
  input  logic out_ready
);
  import rau_pkg::*;

  raw_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end
endmodule

/* rtl/rau_back.sv */
// Back end: binary GCD, then two bit-serial divisions by the GCD, sign fixup
// and output register. Depends on rau_pkg.
module rau_back (
  input  logic clk,
  input  logic rst,
  input  rau_pkg::raw_t raw,
  input  logic raw_valid,
  output logic raw_ready,
  output rau_pkg::res_t res,
  output logic res_valid,
  input  logic res_ready
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIVN = 3'd2;
  localparam logic [2:0] S_DIVD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [WideWidth-1:0] x, y, mn, md, quo, rem, g;
  logic [6:0] shift;
  logic [5:0] bitn;
  logic neg;
  logic [WideWidth:0] rem_sh;
  logic [WideWidth:0] diff;

  assign raw_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  assign rem_sh = {rem, quo[WideWidth-1]};
  assign diff = rem_sh - {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (raw_valid) begin
            if (raw.num == '0 || raw.den == '0) state <= S_OUT;
            else state <= S_GCD;
          end
        end
        S_GCD: if (x == y) state <= S_DIVN;
        S_DIVN: if (bitn == 6'd63) state <= S_DIVD;
        S_DIVD: if (bitn == 6'd63) state <= S_OUT;
        S_OUT: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        neg <= raw.num[WideWidth-1] ^ raw.den[WideWidth-1];
        mn <= raw.num[WideWidth-1] ? -raw.num : raw.num;
        md <= raw.den[WideWidth-1] ? -raw.den : raw.den;
        x <= raw.num[WideWidth-1] ? -raw.num : raw.num;
        y <= raw.den[WideWidth-1] ? -raw.den : raw.den;
        shift <= '0;
        bitn <= '0;
        res.den_zero <= 1'b0;
        if (raw.num == '0) begin
          res.res_num <= '0;
          res.res_den <= WideWidth'(1);
        end else if (raw.den == '0) begin
          res.res_num <= raw.num;
          res.res_den <= '0;
          res.den_zero <= 1'b1;
        end
      end
      S_GCD: begin
        if (x == y) begin
          g <= x << shift;
          quo <= mn;
          rem <= '0;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          shift <= shift + 7'd1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        if (!diff[WideWidth]) begin
          rem <= diff[WideWidth-1:0];
          quo <= {quo[WideWidth-2:0], 1'b1};
        end else begin
          rem <= rem_sh[WideWidth-1:0];
          quo <= {quo[WideWidth-2:0], 1'b0};
        end
        bitn <= bitn + 6'd1;
        if (bitn == 6'd63) begin
          if (state == S_DIVN) begin
            res.res_num <= neg ? -{quo[WideWidth-2:0], !diff[WideWidth]}
                               : {quo[WideWidth-2:0], !diff[WideWidth]};
            quo <= md;
            rem <= '0;
          end else begin
            res.res_den <= {quo[WideWidth-2:0], !diff[WideWidth]};
          end
        end
      end
      default: ;
    endcase
  end
endmodule

/* rtl/rational_arithmetic_unit.sv */
// Rational arithmetic unit top level: front end, queue, back end.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
// Usage: a request (req, req_valid/req_ready) carries an operation and two
// 32-bit signed fractions. The result (res, res_valid/res_ready) carries the
// reduced numerator and denominator with den_zero set when the denominator
// is zero and the numerator is not. The front end takes a request only in
// its idle state, forms the cross products and the sum, then offers the raw
// fraction until the queue takes it; the two-entry queue lets it take the
// next request while the back end works. The back end runs a binary GCD of
// shift and subtract steps and two bit-serial restoring divisions by the
// GCD, taking the next item only when idle; a zero numerator or zero
// denominator reaches the output register in the cycle after the back end
// takes it. Sustained throughput is set by the back end.
// A stalled result holds in the back end's output register; the queue then
// fills and req_ready drops. Synchronous reset empties every stage.
module rational_arithmetic_unit (
  input  logic clk,
  input  logic rst,
  input  rau_pkg::req_t req,
  input  logic req_valid,
  output logic req_ready,
  output rau_pkg::res_t res,
  output logic res_valid,
  input  logic res_ready
);
  import rau_pkg::*;

  raw_t f_raw, q_raw;
  logic f_valid, f_ready, q_valid, q_ready;

  rau_front u_front (
    .clk, .rst, .req, .req_valid, .req_ready,
    .raw(f_raw), .raw_valid(f_valid), .raw_ready(f_ready)
  );

  rau_queue u_queue (
    .clk, .rst,
    .in_data(f_raw), .in_valid(f_valid), .in_ready(f_ready),
    .out_data(q_raw), .out_valid(q_valid), .out_ready(q_ready)
  );

  rau_back u_back (
    .clk, .rst,
    .raw(q_raw), .raw_valid(q_valid), .raw_ready(q_ready),
    .res, .res_valid, .res_ready
  );

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result dropped while stalled");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.den_zero |-> !res.res_den[63] && res.res_den != '0)
    else $error("denominator not positive");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.den_zero |-> res.res_den == '0 && res.res_num != '0)
    else $error("zero flag inconsistent");
endmodule
